>>> sv/matrix_vector_transform_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef MATRIX_VECTOR_TRANSFORM_UNIT_DEFINES_SVH
`define MATRIX_VECTOR_TRANSFORM_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define MVT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mvt check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define MVT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mvt check failed");

`endif

>>> sv/mvt_pkg.sv
package mvt_pkg;

  localparam int DATA_W        = 16;
  localparam int NUM_LANES     = 4;
  localparam int FRACTION_BITS = 8;
  localparam int PROD_W        = 2 * DATA_W;
  localparam int SUM_W         = PROD_W + $clog2(NUM_LANES);
  localparam int ROW_W         = NUM_LANES * DATA_W;
  localparam int CFG_ADDR_W    = $clog2(NUM_LANES) + 3;
  localparam int REG_IDX_W     = $clog2(NUM_LANES);

  // Row register indexes
  localparam logic [REG_IDX_W-1:0] REG_ROW0 = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROW1 = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROW2 = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_ROW3 = 2'd3;

  // Identity matrix in Q8.8
  localparam logic [ROW_W-1:0] ROW0_RESET = 64'h0000_0000_0000_0100;
  localparam logic [ROW_W-1:0] ROW1_RESET = 64'h0000_0000_0100_0000;
  localparam logic [ROW_W-1:0] ROW2_RESET = 64'h0000_0100_0000_0000;
  localparam logic [ROW_W-1:0] ROW3_RESET = 64'h0100_0000_0000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] vec_x;
    logic signed [DATA_W-1:0] vec_y;
    logic signed [DATA_W-1:0] vec_z;
    logic signed [DATA_W-1:0] vec_w;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] out_x;
    logic signed [DATA_W-1:0] out_y;
    logic signed [DATA_W-1:0] out_z;
    logic signed [DATA_W-1:0] out_w;
    logic                     saturated;
  } out_item_t;

  // What one lane hands to the merge stage
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     clip;
  } lane_res_t;

  // Stage load enables from the top-level flow control
  typedef struct packed {
    logic s1_ld;
    logic out_ld;
  } pipe_ctl_t;

endpackage

>>> sv/mvt_lane.sv
module mvt_lane
  import mvt_pkg::*;
#(
  parameter int FRACTION_BITS = mvt_pkg::FRACTION_BITS
)
(
  input  logic             clk,
  input  pipe_ctl_t        ctl,
  input  logic [ROW_W-1:0] row,
  input  in_item_t         vec,
  output lane_res_t        res
);

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((2 ** (DATA_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);
  localparam logic signed [DATA_W-1:0] OUT_HI = {1'b0, {(DATA_W - 1){1'b1}}};
  localparam logic signed [DATA_W-1:0] OUT_LO = {1'b1, {(DATA_W - 1){1'b0}}};

  logic signed [DATA_W-1:0] comp [NUM_LANES];
  logic signed [DATA_W-1:0] ent  [NUM_LANES];
  logic signed [PROD_W-1:0] prod_r [NUM_LANES];
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  shifted;

  assign comp[0] = vec.vec_x;
  assign comp[1] = vec.vec_y;
  assign comp[2] = vec.vec_z;
  assign comp[3] = vec.vec_w;

  always_comb begin
    for (int c = 0; c < NUM_LANES; c++) begin
      ent[c] = $signed(row[DATA_W*c +: DATA_W]);
    end
  end

  // Stage 1: one product per column
  always_ff @(posedge clk) begin
    if (ctl.s1_ld) begin
      for (int c = 0; c < NUM_LANES; c++) begin
        prod_r[c] <= ent[c] * comp[c];
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int c = 0; c < NUM_LANES; c++) begin
      sum = sum + SUM_W'(prod_r[c]);
    end
    // floor shift, then clip to the output range
    shifted = sum >>> FRACTION_BITS;
    if (shifted > SAT_HI) begin
      res.value = OUT_HI;
      res.clip  = 1'b1;
    end else if (shifted < SAT_LO) begin
      res.value = OUT_LO;
      res.clip  = 1'b1;
    end else begin
      res.value = shifted[DATA_W-1:0];
      res.clip  = 1'b0;
    end
  end

endmodule

>>> sv/mvt_merge.sv
module mvt_merge
  import mvt_pkg::*;
(
  input  logic                            clk,
  input  pipe_ctl_t                       ctl,
  input  lane_res_t [NUM_LANES-1:0]       res,
  output out_item_t                       out_item
);

  out_item_t out_r;
  out_item_t out_nxt;
  logic      any_clip;

  always_comb begin
    any_clip = 1'b0;
    for (int l = 0; l < NUM_LANES; l++) begin
      any_clip = any_clip | res[l].clip;
    end
    out_nxt.out_x     = res[0].value;
    out_nxt.out_y     = res[1].value;
    out_nxt.out_z     = res[2].value;
    out_nxt.out_w     = res[3].value;
    out_nxt.saturated = any_clip;
  end

  // Hold while the result is stalled
  always_ff @(posedge clk) begin
    if (ctl.out_ld) begin
      out_r <= out_nxt;
    end
  end

  assign out_item = out_r;

endmodule

>>> sv/matrix_vector_transform_unit.sv
// 4x4 matrix times 4-vector transform in signed Q8.8. Takes one vector per
// clock unless in_stall is raised and returns one result per vector: the
// products are registered in the four multiplier lanes (one lane per matrix
// row, four 16x16 products each), then pass through the lane adders, floor
// shift and clip into the merge output register. Components
// that overflow clip to the 16-bit range and set saturated. The matrix rows
// sit at byte addresses 0, 8, 16 and 24 of the 64-bit config port and reset
// to the identity; write them only while no item is in flight.
module matrix_vector_transform_unit
  import mvt_pkg::*;
#(
  parameter int FRACTION_BITS = mvt_pkg::FRACTION_BITS
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [ROW_W-1:0]      cfg_pwdata,
  output logic [ROW_W-1:0]      cfg_prdata,
  output logic                  cfg_pready
);

  logic [ROW_W-1:0]          row_r [NUM_LANES];
  logic [REG_IDX_W-1:0]      cfg_idx;
  logic                      cfg_wr;
  logic                      s1_valid_r;
  logic                      out_valid_r;
  logic                      out_adv;
  logic                      s1_adv;
  pipe_ctl_t                 ctl;
  lane_res_t [NUM_LANES-1:0] lane_res;

  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = row_r[cfg_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[REG_ROW0] <= ROW0_RESET;
      row_r[REG_ROW1] <= ROW1_RESET;
      row_r[REG_ROW2] <= ROW2_RESET;
      row_r[REG_ROW3] <= ROW3_RESET;
    end else if (cfg_wr) begin
      row_r[cfg_idx] <= cfg_pwdata;
    end
  end

  // Each stage moves when empty or when the stage after it moves
  assign out_adv    = !out_valid_r || !out_stall;
  assign s1_adv     = !s1_valid_r || out_adv;
  assign in_stall   = !s1_adv;
  assign ctl.s1_ld  = in_valid && s1_adv;
  assign ctl.out_ld = s1_valid_r && out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_valid_r <= in_valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  assign out_valid = out_valid_r;

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    mvt_lane #(
      .FRACTION_BITS (FRACTION_BITS)
    ) u_lane (
      .clk (clk),
      .ctl (ctl),
      .row (row_r[l]),
      .vec (in_data),
      .res (lane_res[l])
    );
  end

  mvt_merge u_merge (
    .clk      (clk),
    .ctl      (ctl),
    .res      (lane_res),
    .out_item (out_data)
  );

endmodule

>>> sv/mvt_checker.sv
`include "matrix_vector_transform_unit_defines.svh"

module mvt_checker
  import mvt_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  logic at_limit;

  // some component sits at a rail
  assign at_limit =
    out_data.out_x == 16'sh7FFF || out_data.out_x == 16'sh8000 ||
    out_data.out_y == 16'sh7FFF || out_data.out_y == 16'sh8000 ||
    out_data.out_z == 16'sh7FFF || out_data.out_z == 16'sh8000 ||
    out_data.out_w == 16'sh7FFF || out_data.out_w == 16'sh8000;

  `MVT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  `MVT_ASSERT_NOW(a_stall_only_full, in_stall, out_valid && out_stall)
  `MVT_ASSERT_NEXT(a_result_follows, in_valid && !in_stall, ##1 out_valid)
  `MVT_ASSERT_NOW(a_sat_at_limit, out_valid && out_data.saturated, at_limit)

endmodule

bind matrix_vector_transform_unit mvt_checker u_mvt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
